// ----- sv/idi_pkg.sv -----
// Shared constants, codes and word types of the indent/dedent token inserter.
package idi_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned TAB_WIDTH   = 8;
  localparam int unsigned MAX_COLUMN  = 255;

  localparam int unsigned COL_W = $clog2(MAX_COLUMN + 1);
  localparam int unsigned TOP_W = $clog2(STACK_DEPTH);
  localparam int unsigned PH_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int unsigned SUM_W = COL_W + $clog2(TAB_WIDTH + 1) + 1;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned LINE_W = 20;
  localparam int unsigned CPOS_W = 16;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_SPACE   = 3'd0,
    ACT_TAB     = 3'd1,
    ACT_COMMENT = 3'd2,
    ACT_NEWLINE = 3'd3,
    ACT_EOF     = 3'd4,
    ACT_SIG     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_INDENT = 2'd1,
    KIND_DEDENT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TAB       = 2'd1,
    ERR_UNMATCHED = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_e;

  // Work classes handed from front to back.
  typedef enum logic [1:0] {
    OP_PASS    = 2'd0,
    OP_EOF     = 2'd1,
    OP_MEASURE = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_HEAD   = 4'b0001,
    ST_DEDENT = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_TAIL   = 4'b1000
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  alt;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic [CPOS_W-1:0] cpos;
  } qword_t;

  typedef struct packed {
    kind_e             kind;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic [CPOS_W-1:0] cpos;
    err_e              err;
    logic              last;
  } rword_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] alt;
  } level_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage

// ----- sv/idi_intf.sv -----
// Valid/ready channel interfaces for input tokens and result tokens.
interface idi_tok_if;
  logic                              valid;
  logic                              ready;
  logic [idi_pkg::ACT_W-1:0]         action;
  logic [idi_pkg::TAG_W-1:0]         token_tag;
  logic [idi_pkg::LINE_W-1:0]        src_line;
  logic [idi_pkg::CPOS_W-1:0]        src_column;

  modport source (output valid, action, token_tag, src_line, src_column,
                  input ready);
  modport sink   (input valid, action, token_tag, src_line, src_column,
                  output ready);
endinterface

interface idi_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        out_kind;
  logic [idi_pkg::TAG_W-1:0]         out_tag;
  logic [idi_pkg::LINE_W-1:0]        out_line;
  logic [idi_pkg::CPOS_W-1:0]        out_column;
  logic [1:0]                        error_code;
  logic                              last_of_run;

  modport source (output valid, out_kind, out_tag, out_line, out_column, error_code,
                  last_of_run, input ready);
  modport sink   (input valid, out_kind, out_tag, out_line, out_column, error_code,
                  last_of_run, output ready);
endinterface

// ----- sv/idi_front.sv -----
// Front end: accepts tokens, tracks pending columns and classifies work words.
module idi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  idi_tok_if.sink         tok_i,
  input  idi_pkg::qstat_t qstat_i,
  output logic            push_o,
  output idi_pkg::qword_t word_o
);

  logic [idi_pkg::COL_W-1:0] col_q, col_d, alt_q, alt_d;
  logic [idi_pkg::PH_W-1:0]  phase_q, phase_d;
  logic                      measuring_q, measuring_d;
  logic                      accept;
  logic                      push;

  function automatic logic [idi_pkg::COL_W-1:0] sat_col(
    input logic [idi_pkg::SUM_W-1:0] v
  );
    logic [idi_pkg::COL_W-1:0] r;
    if (v > idi_pkg::SUM_W'(idi_pkg::MAX_COLUMN)) begin
      r = idi_pkg::COL_W'(idi_pkg::MAX_COLUMN);
    end else begin
      r = v[idi_pkg::COL_W-1:0];
    end
    return r;
  endfunction

  assign tok_i.ready = !qstat_i.full;
  assign accept      = tok_i.valid && tok_i.ready;

  always_comb begin
    col_d       = col_q;
    alt_d       = alt_q;
    phase_d     = phase_q;
    measuring_d = measuring_q;
    push        = 1'b0;
    word_o.op   = idi_pkg::OP_PASS;
    word_o.col  = col_q;
    word_o.alt  = alt_q;
    word_o.tag  = tok_i.token_tag;
    word_o.line = tok_i.src_line;
    word_o.cpos = tok_i.src_column;
    case (tok_i.action)
      idi_pkg::ACT_SPACE: begin
        col_d   = sat_col(idi_pkg::SUM_W'(col_q) + idi_pkg::SUM_W'(1));
        alt_d   = sat_col(idi_pkg::SUM_W'(alt_q) + idi_pkg::SUM_W'(1));
        // phase = column mod tab width; meaningless once saturated
        phase_d = (phase_q == idi_pkg::PH_W'(idi_pkg::TAB_WIDTH - 1)) ? '0
                                                                      : phase_q + 1'b1;
      end
      idi_pkg::ACT_TAB: begin
        col_d   = sat_col(idi_pkg::SUM_W'(col_q) + idi_pkg::SUM_W'(idi_pkg::TAB_WIDTH)
                          - idi_pkg::SUM_W'(phase_q));
        alt_d   = sat_col(idi_pkg::SUM_W'(alt_q) + idi_pkg::SUM_W'(1));
        phase_d = '0;
      end
      idi_pkg::ACT_COMMENT: begin
        push = 1'b1;
      end
      idi_pkg::ACT_NEWLINE: begin
        push        = 1'b1;
        col_d       = '0;
        alt_d       = '0;
        phase_d     = '0;
        measuring_d = 1'b1;
      end
      idi_pkg::ACT_EOF: begin
        push      = 1'b1;
        word_o.op = idi_pkg::OP_EOF;
      end
      default: begin
        // significant token
        push        = 1'b1;
        word_o.op   = measuring_q ? idi_pkg::OP_MEASURE : idi_pkg::OP_PASS;
        measuring_d = 1'b0;
      end
    endcase
  end

  assign push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      alt_q       <= '0;
      phase_q     <= '0;
      measuring_q <= 1'b1;
    end else if (accept) begin
      col_q       <= col_d;
      alt_q       <= alt_d;
      phase_q     <= phase_d;
      measuring_q <= measuring_d;
    end
  end

endmodule

// ----- sv/idi_fifo.sv -----
// Short work queue between front and back.
module idi_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  idi_pkg::qword_t word_i,
  input  logic            pop_i,
  output idi_pkg::qstat_t qstat_o,
  output idi_pkg::qword_t head_o
);

  idi_pkg::qword_t                mem_q [idi_pkg::FIFO_DEPTH];
  logic [idi_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [idi_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                           do_push, do_pop;

  function automatic logic [idi_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [idi_pkg::FIFO_PTR_W-1:0] p
  );
    logic [idi_pkg::FIFO_PTR_W-1:0] r;
    r = (p == idi_pkg::FIFO_PTR_W'(idi_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign qstat_o.full  = (cnt_q == idi_pkg::FIFO_CNT_W'(idi_pkg::FIFO_DEPTH));
  assign qstat_o.valid = (cnt_q != '0);
  assign head_o        = mem_q[rd_ptr_q];
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && qstat_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> qstat_o.valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= idi_pkg::FIFO_CNT_W'(idi_pkg::FIFO_DEPTH)) else $error("queue count range");

endmodule

// ----- sv/idi_back.sv -----
// Back end: level stack, INDENT/DEDENT sequencing and the result register.
module idi_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  idi_pkg::qstat_t qstat_i,
  input  idi_pkg::qword_t head_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output idi_pkg::rword_t res_o
);

  idi_pkg::state_e           state_q, state_d;
  logic [idi_pkg::TOP_W-1:0] top_q, top_d;
  idi_pkg::err_e             tail_err_q, tail_err_d;
  idi_pkg::rword_t           out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  // entry zero is the fixed base level and is never stored
  idi_pkg::level_t           levels_q [idi_pkg::STACK_DEPTH];
  idi_pkg::level_t           top_lvl;
  logic                      lvl_we;
  logic [idi_pkg::TOP_W-1:0] lvl_waddr;

  logic                      emit_ok, emit, last, top_zero;
  idi_pkg::kind_e            kind;
  idi_pkg::err_e             err;

  assign top_zero = (top_q == '0);
  assign top_lvl  = top_zero ? '0 : levels_q[top_q];
  assign emit_ok  = !out_valid_q || res_ready_i;

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    tail_err_d  = tail_err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    lvl_we      = 1'b0;
    lvl_waddr   = top_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    last        = 1'b0;
    kind        = idi_pkg::KIND_PASS;
    err         = idi_pkg::ERR_NONE;

    if (emit_ok && qstat_i.valid) begin
      emit = 1'b1;
      case (state_q)
        idi_pkg::ST_HEAD: begin
          case (head_i.op)
            idi_pkg::OP_EOF: begin
              if (!top_zero) begin
                kind    = idi_pkg::KIND_DEDENT;
                top_d   = top_q - 1'b1;
                state_d = idi_pkg::ST_FLUSH;
              end else begin
                last = 1'b1;
              end
            end
            idi_pkg::OP_MEASURE: begin
              if (head_i.col == top_lvl.col) begin
                last = 1'b1;
                if (head_i.alt != top_lvl.alt) begin
                  err = idi_pkg::ERR_TAB;
                end
              end else if (head_i.col > top_lvl.col) begin
                if (top_q == idi_pkg::TOP_W'(idi_pkg::STACK_DEPTH - 1)) begin
                  last = 1'b1;
                  err  = idi_pkg::ERR_OVERFLOW;
                end else begin
                  kind       = idi_pkg::KIND_INDENT;
                  tail_err_d = (head_i.alt <= top_lvl.alt) ? idi_pkg::ERR_TAB
                                                           : idi_pkg::ERR_NONE;
                  top_d      = top_q + 1'b1;
                  lvl_we     = 1'b1;
                  lvl_waddr  = top_q + 1'b1;
                  state_d    = idi_pkg::ST_TAIL;
                end
              end else begin
                // shallower: top is above base here since base is zero
                kind    = idi_pkg::KIND_DEDENT;
                top_d   = top_q - 1'b1;
                state_d = idi_pkg::ST_DEDENT;
              end
            end
            default: begin
              last = 1'b1;
            end
          endcase
        end
        idi_pkg::ST_DEDENT: begin
          if (!top_zero && (head_i.col < top_lvl.col)) begin
            kind  = idi_pkg::KIND_DEDENT;
            top_d = top_q - 1'b1;
          end else begin
            last    = 1'b1;
            state_d = idi_pkg::ST_HEAD;
            if (head_i.col != top_lvl.col) begin
              err    = idi_pkg::ERR_UNMATCHED;
              lvl_we = !top_zero;
            end else if (head_i.alt != top_lvl.alt) begin
              err = idi_pkg::ERR_TAB;
            end
          end
        end
        idi_pkg::ST_FLUSH: begin
          if (!top_zero) begin
            kind  = idi_pkg::KIND_DEDENT;
            top_d = top_q - 1'b1;
          end else begin
            last    = 1'b1;
            state_d = idi_pkg::ST_HEAD;
          end
        end
        idi_pkg::ST_TAIL: begin
          last    = 1'b1;
          err     = tail_err_q;
          state_d = idi_pkg::ST_HEAD;
        end
        default: begin
          emit    = 1'b0;
          state_d = idi_pkg::ST_HEAD;
        end
      endcase
    end

    if (emit) begin
      pop_o       = last;
      out_valid_d = 1'b1;
      out_d.kind  = kind;
      out_d.tag   = head_i.tag;
      out_d.line  = head_i.line;
      out_d.cpos  = head_i.cpos;
      out_d.err   = err;
      out_d.last  = last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      levels_q[lvl_waddr] <= '{col: head_i.col, alt: head_i.alt};
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idi_pkg::ST_HEAD;
      top_q       <= '0;
      tail_err_q  <= idi_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      tail_err_q  <= tail_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= idi_pkg::TOP_W'(idi_pkg::STACK_DEPTH - 1)) else $error("stack top range");
  a_run_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != idi_pkg::ST_HEAD |-> qstat_i.valid) else $error("run without queued word");
  a_err_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.err != idi_pkg::ERR_NONE) |-> out_q.last)
    else $error("error flagged before last result");
  a_indent_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (kind == idi_pkg::KIND_INDENT) |=> state_q == idi_pkg::ST_TAIL)
    else $error("INDENT not followed by tail");

endmodule

// ----- sv/indent_dedent_token_inserter_core.sv -----
// Top level of the indent/dedent token inserter: front, work queue and back.
// The back registers the results of each accepted word taken from the work queue.
// Throughput: one input word per cycle for spaces, tabs and plain tokens while the
//   queue has room and results are taken; an indenting line gives INDENT and token,
//   a pop or end of file over n levels gives n DEDENTs, set by the back sequencer.
// Reset (rst_ni, async, active low): stack to base entry, pending columns zero,
//   line measuring armed, queue and result register empty; no clearing pass.
module indent_dedent_token_inserter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  idi_tok_if.sink    tok_i,
  idi_res_if.source  res_o
);

  // front -> queue
  logic            push;
  idi_pkg::qword_t push_word;
  // queue -> front/back
  idi_pkg::qstat_t qstat;
  idi_pkg::qword_t head;
  // back -> queue
  logic            pop;
  // result register
  idi_pkg::rword_t res;

  // Front tracks the column pair and the measuring flag; it needs only the input
  // stream and queue room, so it runs ahead while the back works off DEDENT runs.
  idi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok_i),
    .qstat_i (qstat),
    .push_o  (push),
    .word_o  (push_word)
  );

  idi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  // Back holds the head word until its last result goes into the output register.
  idi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.out_kind    = res.kind;
  assign res_o.out_tag     = res.tag;
  assign res_o.out_line    = res.line;
  assign res_o.out_column  = res.cpos;
  assign res_o.error_code  = res.err;
  assign res_o.last_of_run = res.last;

endmodule
